// ===== hw/rtl/dpr_pkg.sv =====
// types, constants and helpers shared by the depth pixel reprojection block
`timescale 1ns / 1ps
package dpr_pkg;

   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 63;

   localparam logic [CSR_IDX_W-1:0] CSR_INV_COL    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_ROW    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT0       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT1       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT2       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANS      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_SIZE = 3'd7;

   localparam logic [61:0] RST_INV_COL = 62'd268435456;
   localparam logic [61:0] RST_INV_ROW = 62'd268435456;
   localparam logic [62:0] RST_ROT0    = 63'd524288;
   localparam logic [62:0] RST_ROT1    = 63'd1099511627776;
   localparam logic [62:0] RST_ROT2    = 63'd2305843009213693952;
   localparam logic [62:0] RST_TRANS   = 63'd0;
   localparam logic [62:0] RST_TARGET  = 63'd16;
   localparam logic [29:0] RST_IMAGE   = 30'd0;

   localparam int unsigned RECIP_STEPS = 49;
   localparam int unsigned DEPTH_W     = 32;
   localparam logic [RECIP_STEPS-1:0] RECIP_NUM = {1'b1, 48'b0};
   localparam int unsigned PROJ_STEPS  = 35;
   localparam int unsigned DEN_W       = 63;

   localparam logic signed [63:0] DEN_MIN  = 64'sd34360;
   localparam logic [34:0]        QUOT_CAP = 35'h4_0000_0000;

   typedef struct packed {
      logic signed [19:0] from_col;
      logic signed [19:0] from_row;
      logic [31:0]        depth_sample;
   } req_type;

   typedef struct packed {
      logic               valid_res;
      logic signed [31:0] to_col;
      logic signed [31:0] to_row;
   } rsp_type;

   typedef struct packed {
      logic signed [30:0] col_scale;
      logic signed [30:0] col_offset;
      logic signed [30:0] row_scale;
      logic signed [30:0] row_offset;
      logic [2:0][62:0]   rot;
      logic [62:0]        trans;
      logic [62:0]        target;
      logic [14:0]        width;
      logic [14:0]        height;
   } cfg_type;

   typedef struct packed {
      logic               ok;
      logic signed [57:0] a0;
      logic signed [57:0] a1;
      logic signed [57:0] a2;
   } bp_type;

   typedef struct packed {
      logic               ok;
      logic signed [63:0] n0;
      logic signed [63:0] n1;
      logic signed [63:0] n2;
   } nsum_type;

   typedef struct packed {
      logic        ovf;
      logic        neg;
      logic [62:0] rem;
      logic [34:0] low;
   } lane_type;

   typedef struct packed {
      logic        ok;
      logic [62:0] den;
      lane_type    col;
      lane_type    row;
   } numer_type;

   function automatic logic signed [20:0] field21(input logic [62:0] v, input int unsigned k);
      return v[21*k +: 21];
   endfunction

endpackage

// ===== hw/rtl/dpr_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module dpr_div #(
   parameter int unsigned STEPS  = 35,
   parameter int unsigned DEN_W  = 63,
   parameter int unsigned SIDE_W = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [DEN_W-1:0]  in_rem,
   input  logic [STEPS-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [STEPS-1:0]  out_quot,
   output logic [SIDE_W-1:0] out_side
);

   logic              vld_ff  [STEPS];
   logic [STEPS-1:0]  sh_ff   [STEPS];
   logic [SIDE_W-1:0] side_ff [STEPS];
   logic [DEN_W-1:0]  rem_ff  [STEPS-1];
   logic [DEN_W-1:0]  den_ff  [STEPS-1];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [DEN_W-1:0]  rem_p;
      logic [DEN_W-1:0]  den_p;
      logic [STEPS-1:0]  sh_p;
      logic [SIDE_W-1:0] side_p;
      logic              vld_p;
      logic [DEN_W:0]    trial;
      logic              take;

      if (k == 0) begin : g_head
         assign rem_p  = in_rem;
         assign den_p  = in_den;
         assign sh_p   = in_num;
         assign side_p = in_side;
         assign vld_p  = in_valid;
      end else begin : g_body
         assign rem_p  = rem_ff[k-1];
         assign den_p  = den_ff[k-1];
         assign sh_p   = sh_ff[k-1];
         assign side_p = side_ff[k-1];
         assign vld_p  = vld_ff[k-1];
      end

      assign trial = {rem_p, sh_p[STEPS-1]};
      assign take  = trial >= {1'b0, den_p};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sh_ff[k]   <= {sh_p[STEPS-2:0], take};
            side_ff[k] <= side_p;
         end
      end

      if (k < STEPS - 1) begin : g_carry
         logic [DEN_W-1:0] rem_in;
         assign rem_in = take ? DEN_W'(trial - {1'b0, den_p}) : trial[DEN_W-1:0];
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_in;
               den_ff[k] <= den_p;
            end
         end
      end
   end

   assign out_valid = vld_ff[STEPS-1];
   assign out_quot  = sh_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

// ===== hw/rtl/dpr_backproj.sv =====
// range check, inverse intrinsics and rotation, five stages
`timescale 1ns / 1ps
module dpr_backproj (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  dpr_pkg::req_type  in_data,
   input  dpr_pkg::cfg_type  cfg,
   output logic              out_valid,
   output logic [31:0]       out_depth,
   output dpr_pkg::bp_type   out_data
);

   logic               col_ok, row_ok, ok1_in;
   logic [4:0]         vld_ff;
   logic [4:0]         ok_ff;
   logic [31:0]        depth_ff [5];
   logic signed [19:0] col1_ff, row1_ff;
   logic signed [50:0] mc_in, mr_in, mc_ff, mr_ff;
   logic signed [51:0] sc_in, sr_in;
   logic signed [35:0] fw_ff [2];
   logic signed [56:0] prod_in [3][2];
   logic signed [56:0] prod_ff [3][2];
   logic signed [57:0] a_in [3];
   logic signed [57:0] a_ff [3];

   always_comb begin
      col_ok = !in_data.from_col[19] &&
               ({1'b0, in_data.from_col[18:0]} < {1'b0, cfg.width, 4'b0});
      row_ok = !in_data.from_row[19] &&
               ({1'b0, in_data.from_row[18:0]} < {1'b0, cfg.height, 4'b0});
      ok1_in = col_ok && row_ok && (in_data.depth_sample != '0);
   end

   always_comb begin
      mc_in = 51'(cfg.col_scale) * 51'(col1_ff);
      mr_in = 51'(cfg.row_scale) * 51'(row1_ff);
      sc_in = 52'(mc_ff) + (52'(cfg.col_offset) <<< 4);
      sr_in = 52'(mr_ff) + (52'(cfg.row_offset) <<< 4);
      for (int i = 0; i < 3; i++) begin
         prod_in[i][0] = 57'(dpr_pkg::field21(cfg.rot[i], 0)) * 57'(fw_ff[0]);
         prod_in[i][1] = 57'(dpr_pkg::field21(cfg.rot[i], 1)) * 57'(fw_ff[1]);
         a_in[i] = 58'(prod_ff[i][0]) + 58'(prod_ff[i][1]) +
                   (58'(dpr_pkg::field21(cfg.rot[i], 2)) <<< 16);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ok_ff       <= {ok_ff[3:0], ok1_in};
         depth_ff[0] <= in_data.depth_sample;
         for (int k = 1; k < 5; k++) begin
            depth_ff[k] <= depth_ff[k-1];
         end
         col1_ff  <= in_data.from_col;
         row1_ff  <= in_data.from_row;
         mc_ff    <= mc_in;
         mr_ff    <= mr_in;
         fw_ff[0] <= sc_in[51:16];
         fw_ff[1] <= sr_in[51:16];
         prod_ff  <= prod_in;
         a_ff     <= a_in;
      end
   end

   always_comb begin
      out_valid   = vld_ff[4];
      out_depth   = depth_ff[4];
      out_data.ok = ok_ff[4];
      out_data.a0 = a_ff[0];
      out_data.a1 = a_ff[1];
      out_data.a2 = a_ff[2];
   end

endmodule

// ===== hw/rtl/dpr_transl.sv =====
// translation scaled by reciprocal depth, added to the rotated ray
`timescale 1ns / 1ps
module dpr_transl (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [48:0]       in_zinv,
   input  dpr_pkg::bp_type   in_data,
   input  dpr_pkg::cfg_type  cfg,
   output logic              out_valid,
   output dpr_pkg::nsum_type out_data
);

   logic [32:0]        zhi;
   logic [15:0]        zlo;
   logic signed [20:0] t_v [3];
   logic signed [54:0] th_in [3];
   logic signed [54:0] th_ff [3];
   logic signed [37:0] tl_in [3];
   logic signed [37:0] tl_ff [3];
   logic signed [57:0] a_v [3];
   logic signed [63:0] n_in [3];
   logic               vld6_ff, vld7_ff;
   dpr_pkg::bp_type    bp_ff;
   dpr_pkg::nsum_type  n_ff;

   always_comb begin
      zhi = in_zinv[48:16];
      zlo = in_zinv[15:0];
      a_v[0] = bp_ff.a0;
      a_v[1] = bp_ff.a1;
      a_v[2] = bp_ff.a2;
      for (int i = 0; i < 3; i++) begin
         t_v[i]   = dpr_pkg::field21(cfg.trans, i);
         th_in[i] = 55'(t_v[i]) * 55'($signed({1'b0, zhi}));
         tl_in[i] = 38'(t_v[i]) * 38'($signed({1'b0, zlo}));
         n_in[i]  = 64'(a_v[i]) + (64'(th_ff[i]) <<< 8) + 64'(tl_ff[i] >>> 8);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld6_ff <= 1'b0;
         vld7_ff <= 1'b0;
      end else if (en) begin
         vld6_ff <= in_valid;
         vld7_ff <= vld6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bp_ff   <= in_data;
         th_ff   <= th_in;
         tl_ff   <= tl_in;
         n_ff.ok <= bp_ff.ok;
         n_ff.n0 <= n_in[0];
         n_ff.n1 <= n_in[1];
         n_ff.n2 <= n_in[2];
      end
   end

   assign out_valid = vld7_ff;
   assign out_data  = n_ff;

endmodule

// ===== hw/rtl/dpr_numer.sv =====
// denominator check and scaled numerators for the two projection dividers
`timescale 1ns / 1ps
module dpr_numer (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  dpr_pkg::nsum_type  in_data,
   input  dpr_pkg::cfg_type   cfg,
   output logic               out_valid,
   output dpr_pkg::numer_type out_data
);

   logic [3:0]         vld_ff;
   logic signed [20:0] focal;
   logic [20:0]        fmag;
   logic signed [63:0] nabs [2];
   logic               ok8_ff, ok9_ff, ok10_ff;
   logic [62:0]        den8_ff, den9_ff, den10_ff;
   logic [61:0]        mag8_ff [2];
   logic [1:0]         neg8_ff, neg9_ff, neg10_ff;
   logic [51:0]        mh_in [2];
   logic [51:0]        ml_in [2];
   logic [51:0]        mh9_ff [2];
   logic [51:0]        ml9_ff [2];
   logic [82:0]        p_in [2];
   logic [82:0]        p10_ff [2];
   logic [62:0]        hi_v [2];
   dpr_pkg::lane_type  lane_in [2];
   dpr_pkg::numer_type out_ff;

   always_comb begin
      focal   = dpr_pkg::field21(cfg.target, 0);
      fmag    = focal[20] ? 21'(-focal) : 21'(focal);
      nabs[0] = in_data.n0[63] ? -in_data.n0 : in_data.n0;
      nabs[1] = in_data.n1[63] ? -in_data.n1 : in_data.n1;
      for (int l = 0; l < 2; l++) begin
         mh_in[l] = 52'(mag8_ff[l][61:31]) * 52'(fmag);
         ml_in[l] = 52'(mag8_ff[l][30:0]) * 52'(fmag);
         p_in[l]  = {mh9_ff[l], 31'b0} + 83'(ml9_ff[l]);
         hi_v[l]  = {3'b0, p10_ff[l][82:23]};
         lane_in[l].ovf = hi_v[l] >= den10_ff;
         lane_in[l].neg = neg10_ff[l];
         lane_in[l].rem = hi_v[l];
         lane_in[l].low = {p10_ff[l][22:0], 12'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ok8_ff     <= in_data.ok && (in_data.n2 >= dpr_pkg::DEN_MIN);
         den8_ff    <= in_data.n2[62:0];
         mag8_ff[0] <= nabs[0][61:0];
         mag8_ff[1] <= nabs[1][61:0];
         neg8_ff    <= {in_data.n1[63] ^ focal[20], in_data.n0[63] ^ focal[20]};
         ok9_ff     <= ok8_ff;
         den9_ff    <= den8_ff;
         neg9_ff    <= neg8_ff;
         mh9_ff     <= mh_in;
         ml9_ff     <= ml_in;
         ok10_ff    <= ok9_ff;
         den10_ff   <= den9_ff;
         neg10_ff   <= neg9_ff;
         p10_ff     <= p_in;
         out_ff.ok  <= ok10_ff;
         out_ff.den <= den10_ff;
         out_ff.col <= lane_in[0];
         out_ff.row <= lane_in[1];
      end
   end

   assign out_valid = vld_ff[3];
   assign out_data  = out_ff;

endmodule

// ===== hw/rtl/depth_pixel_reprojection.sv =====
// top level: config registers, pipeline assembly, output register
// throughput: one transfer per cycle; a held response freezes the whole pipeline
// reciprocal depth takes 49 divider stages, each projection 35 divider stages
// synchronous reset clears all valid bits and loads the register defaults
`timescale 1ns / 1ps
module depth_pixel_reprojection (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  dpr_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output dpr_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [dpr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dpr_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   logic [61:0] inv_col_ff, inv_row_ff;
   logic [62:0] rot0_ff, rot1_ff, rot2_ff, trans_ff, target_ff;
   logic [29:0] img_ff;
   dpr_pkg::cfg_type cfg;

   logic                     en;
   logic                     bp_valid;
   logic [31:0]              bp_depth;
   dpr_pkg::bp_type          bp_data;
   logic                     rc_valid;
   logic [48:0]              rc_zinv;
   dpr_pkg::bp_type          rc_data;
   logic                     ns_valid;
   dpr_pkg::nsum_type        ns_data;
   logic                     nm_valid;
   dpr_pkg::numer_type       nm_data;
   logic                     qc_valid;
   logic [34:0]              qc_quot, qr_quot;
   logic [2:0]               qc_side;
   logic [1:0]               qr_side;
   dpr_pkg::rsp_type         rsp_in;
   logic                     rsp_valid_ff;
   dpr_pkg::rsp_type         rsp_data_ff;

   function automatic logic signed [31:0] finish(input logic [34:0] q, input logic ovf,
                                                 input logic neg, input logic signed [20:0] p);
      logic [34:0]        qc;
      logic signed [37:0] v;
      qc = (ovf || (q > dpr_pkg::QUOT_CAP)) ? dpr_pkg::QUOT_CAP : q;
      v  = 38'({1'b0, qc});
      if (neg) begin
         v = -v;
      end
      v = v + (38'(p) <<< 12);
      if (v > 38'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -38'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_col_ff <= dpr_pkg::RST_INV_COL;
         inv_row_ff <= dpr_pkg::RST_INV_ROW;
         rot0_ff    <= dpr_pkg::RST_ROT0;
         rot1_ff    <= dpr_pkg::RST_ROT1;
         rot2_ff    <= dpr_pkg::RST_ROT2;
         trans_ff   <= dpr_pkg::RST_TRANS;
         target_ff  <= dpr_pkg::RST_TARGET;
         img_ff     <= dpr_pkg::RST_IMAGE;
      end else if (csr_we) begin
         unique case (csr_index)
            dpr_pkg::CSR_INV_COL:    inv_col_ff <= csr_wdata[61:0];
            dpr_pkg::CSR_INV_ROW:    inv_row_ff <= csr_wdata[61:0];
            dpr_pkg::CSR_ROT0:       rot0_ff    <= csr_wdata;
            dpr_pkg::CSR_ROT1:       rot1_ff    <= csr_wdata;
            dpr_pkg::CSR_ROT2:       rot2_ff    <= csr_wdata;
            dpr_pkg::CSR_TRANS:      trans_ff   <= csr_wdata;
            dpr_pkg::CSR_TARGET:     target_ff  <= csr_wdata;
            dpr_pkg::CSR_IMAGE_SIZE: img_ff     <= csr_wdata[29:0];
         endcase
      end
   end

   always_comb begin
      cfg.col_scale  = inv_col_ff[30:0];
      cfg.col_offset = inv_col_ff[61:31];
      cfg.row_scale  = inv_row_ff[30:0];
      cfg.row_offset = inv_row_ff[61:31];
      cfg.rot[0]     = rot0_ff;
      cfg.rot[1]     = rot1_ff;
      cfg.rot[2]     = rot2_ff;
      cfg.trans      = trans_ff;
      cfg.target     = target_ff;
      cfg.width      = img_ff[14:0];
      cfg.height     = img_ff[29:15];
   end

   // pipeline moves unless a held response is waiting
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   dpr_backproj u_backproj (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid && en),
      .in_data   (req_data),
      .cfg       (cfg),
      .out_valid (bp_valid),
      .out_depth (bp_depth),
      .out_data  (bp_data)
   );

   dpr_div #(
      .STEPS  (dpr_pkg::RECIP_STEPS),
      .DEN_W  (dpr_pkg::DEPTH_W),
      .SIDE_W ($bits(dpr_pkg::bp_type))
   ) u_recip (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (bp_valid),
      .in_rem    ('0),
      .in_num    (dpr_pkg::RECIP_NUM),
      .in_den    (bp_depth),
      .in_side   (bp_data),
      .out_valid (rc_valid),
      .out_quot  (rc_zinv),
      .out_side  (rc_data)
   );

   dpr_transl u_transl (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rc_valid),
      .in_zinv   (rc_zinv),
      .in_data   (rc_data),
      .cfg       (cfg),
      .out_valid (ns_valid),
      .out_data  (ns_data)
   );

   dpr_numer u_numer (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (ns_valid),
      .in_data   (ns_data),
      .cfg       (cfg),
      .out_valid (nm_valid),
      .out_data  (nm_data)
   );

   dpr_div #(
      .STEPS  (dpr_pkg::PROJ_STEPS),
      .DEN_W  (dpr_pkg::DEN_W),
      .SIDE_W (3)
   ) u_div_col (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (nm_valid),
      .in_rem    (nm_data.col.rem),
      .in_num    (nm_data.col.low),
      .in_den    (nm_data.den),
      .in_side   ({nm_data.ok, nm_data.col.ovf, nm_data.col.neg}),
      .out_valid (qc_valid),
      .out_quot  (qc_quot),
      .out_side  (qc_side)
   );

   dpr_div #(
      .STEPS  (dpr_pkg::PROJ_STEPS),
      .DEN_W  (dpr_pkg::DEN_W),
      .SIDE_W (2)
   ) u_div_row (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (nm_valid),
      .in_rem    (nm_data.row.rem),
      .in_num    (nm_data.row.low),
      .in_den    (nm_data.den),
      .in_side   ({nm_data.row.ovf, nm_data.row.neg}),
      .out_valid (),
      .out_quot  (qr_quot),
      .out_side  (qr_side)
   );

   always_comb begin
      rsp_in.valid_res = qc_side[2];
      rsp_in.to_col    = '0;
      rsp_in.to_row    = '0;
      if (qc_side[2]) begin
         rsp_in.to_col = finish(qc_quot, qc_side[1], qc_side[0],
                                dpr_pkg::field21(target_ff, 1));
         rsp_in.to_row = finish(qr_quot, qr_side[1], qr_side[0],
                                dpr_pkg::field21(target_ff, 2));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= qc_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/dpr_checker.sv =====
// port-level checks for the reprojection block and their binding
`timescale 1ns / 1ps
module dpr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input dpr_pkg::rsp_type rsp_data
);

   // no response right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // rejected item carries zero coordinates
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.valid_res |-> rsp_data.to_col == 0 && rsp_data.to_row == 0)
      else $error("invalid response with nonzero coordinates");

   // input only held back by a held response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held response");

   // held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("held response changed");

endmodule

bind depth_pixel_reprojection dpr_checker u_dpr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
